// File: rtl/bbd_pkg.sv
// Shared types and constants of the board bus decoder and interrupt latch.
// Used by bbd_decode and board_bus_decoder_irq_latch_core; no dependencies.
package bbd_pkg;

  // Mirrored battery SRAM size in bytes (power of two, 1 KiB to 64 KiB)
  localparam int SRAM_BYTES = 32768;
  localparam int SRAM_AW    = $clog2(SRAM_BYTES);
  // Number of gate-array interrupt lines (2 to 8)
  localparam int IRQ_LINES  = 8;
  localparam int LINE_AW    = $clog2(IRQ_LINES);

  // Commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  // Targets
  localparam logic [3:0] TGT_UNMAPPED = 4'd0;
  localparam logic [3:0] TGT_INTROM   = 4'd1;
  localparam logic [3:0] TGT_SRAM     = 4'd2;
  localparam logic [3:0] TGT_SOUND    = 4'd3;
  localparam logic [3:0] TGT_PROGROM  = 4'd4;
  localparam logic [3:0] TGT_SUBMCU   = 4'd5;
  localparam logic [3:0] TGT_LCDI     = 4'd6;
  localparam logic [3:0] TGT_LCDD     = 4'd7;
  localparam logic [3:0] TGT_PANEL    = 4'd8;
  localparam logic [3:0] TGT_LOCAL    = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] CFG_FIRST_GEN   = 3'd0;
  localparam logic [2:0] CFG_SUB_MCU     = 3'd1;
  localparam logic [2:0] CFG_ENABLES_OPEN = 3'd2;
  localparam logic [2:0] CFG_HAS_PANEL   = 3'd3;
  localparam logic [2:0] CFG_HAS_DISPLAY = 3'd4;

  // Gate-array register numbers in the later map
  localparam logic [9:0] GA_MODE   = 10'd1;
  localparam logic [9:0] GA_STATUS = 10'd2;
  localparam logic [9:0] GA_LCDI   = 10'd4;
  localparam logic [9:0] GA_LCDD   = 10'd5;

  typedef struct packed {
    logic first_gen;
    logic sub_mcu;
    logic enables_open;
    logic has_panel;
    logic has_display;
  } cfg_t;

  typedef struct packed {
    logic [7:0]           mode;
    logic                 lcd_en;
    logic [7:0]           irq_mask;
    logic [2:0]           latched;
    logic [IRQ_LINES-1:0] levels;
  } state_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [18:0] offset;
    logic [7:0]  data;
  } result_t;

endpackage

// File: rtl/bbd_decode.sv
// Address decode and interrupt-latch update for one transaction.
// Pure combinational; depends on bbd_pkg for types and codes.
module bbd_decode import bbd_pkg::*; (
  input  logic [1:0]  cmd,
  input  logic [23:0] addr,
  input  logic [7:0]  wdata,
  input  logic [2:0]  line,
  input  logic        level,
  input  cfg_t        cfg,
  input  state_t      st,
  output result_t     res,
  output state_t      st_nxt
);

  logic [7:0]  page;
  logic [15:0] off;
  logic [15:0] sram_rel;
  logic [9:0]  ga_reg;
  logic        wr;
  logic        line_ok;
  logic        sram_page;
  logic        prog_page;
  logic        in_sound;
  logic        in_ga;
  logic        in_sub;
  logic        in_f0;
  logic [LINE_AW-1:0] lidx;

  assign page      = addr[23:16];
  assign off       = addr[15:0];
  assign sram_rel  = off - 16'h8000;
  assign ga_reg    = off[9:0];
  assign wr        = (cmd == CMD_WRITE);
  assign line_ok   = ({1'b0, line} < 4'(IRQ_LINES));
  assign lidx      = line[LINE_AW-1:0];
  assign sram_page = cfg.first_gen ? (page == 8'd5) : (page == 8'd10 || page == 8'd11);
  assign prog_page = (page == 8'd1) || (page == 8'd2) || (page == 8'd3) || (page == 8'd4) ||
                     (page == 8'd8) || (page == 8'd9) || (page == 8'd14) || (page == 8'd15);
  assign in_sound  = cfg.first_gen ? (off <= 16'hE03F) : (off <= 16'hE3FF);
  assign in_ga     = (off >= 16'hE400) && (off <= 16'hE7FF);
  assign in_sub    = cfg.sub_mcu && (off >= 16'hEC00) && (off <= 16'hEFFF);
  assign in_f0     = (off[15:8] == 8'hF0);

  always_comb begin
    res    = '0;
    st_nxt = st;
    unique case (cmd)
      CMD_READ, CMD_WRITE: begin
        if (page != 8'd0) begin
          if (sram_page) begin
            res.target = TGT_SRAM;
            res.offset = 19'(off[SRAM_AW-1:0]);
          end else if (!wr && prog_page) begin
            res.target = TGT_PROGROM;
            res.offset = {addr[19], addr[17:0]};
          end else begin
            res.data = wr ? 8'h00 : 8'hFF;
          end
        end else if (off < 16'h8000) begin
          // ROM writes are dropped
          if (!wr) begin
            res.target = TGT_INTROM;
            res.offset = 19'(off);
          end
        end else if (off < 16'hE000) begin
          res.target = TGT_SRAM;
          res.offset = 19'(sram_rel[SRAM_AW-1:0]);
        end else if (in_sound) begin
          res.target = TGT_SOUND;
          res.offset = 19'(off[5:0]);
        end else if (cfg.first_gen) begin
          if (!wr) begin
            if (off == 16'hF106) begin
              res.target     = TGT_LOCAL;
              res.data       = 8'(st.latched);
              st_nxt.latched = 3'd0;
            end else if (in_f0) begin
              st_nxt.mode = off[7:0];
              if (cfg.has_panel) begin
                st_nxt.lcd_en = off[3];
                res.target    = TGT_PANEL;
                res.offset    = 19'(off[7:0]);
              end else begin
                res.data = 8'hFF;
              end
            end else begin
              res.data = 8'hFF;
            end
          end else begin
            if (off == 16'hF104 || off == 16'hF105) begin
              if (cfg.has_display) begin
                res.target = (off == 16'hF104) ? TGT_LCDD : TGT_LCDI;
              end
            end else if (off == 16'hF107) begin
              st_nxt.mode = wdata;
              res.target  = TGT_LOCAL;
            end else if (in_f0) begin
              st_nxt.mode   = off[7:0];
              st_nxt.lcd_en = off[3];
              res.target    = TGT_LOCAL;
            end
          end
        end else if (in_ga) begin
          res.target = TGT_LOCAL;
          if (!wr) begin
            if (ga_reg == GA_STATUS) begin
              res.data       = 8'(st.latched);
              st_nxt.latched = 3'd0;
            end else begin
              res.data = 8'hFF;
            end
          end else begin
            priority if (ga_reg == GA_MODE) begin
              st_nxt.mode   = wdata;
              st_nxt.lcd_en = ~wdata[0];
            end else if (ga_reg == GA_STATUS) begin
              st_nxt.irq_mask = {wdata[6:0], 1'b0};
            end else if (ga_reg == GA_LCDI) begin
              res.target = TGT_LCDI;
            end else if (ga_reg == GA_LCDD) begin
              res.target = TGT_LCDD;
            end else begin
              res.target = TGT_LOCAL;
            end
          end
        end else if (in_sub) begin
          res.target = TGT_SUBMCU;
          res.offset = 19'(off[7:0]);
        end else begin
          res.data = wr ? 8'h00 : 8'hFF;
        end
      end
      CMD_LINE: begin
        if (line_ok) begin
          // latch on a rising edge of an enabled line
          if (level && !st.levels[lidx] && st.irq_mask[line]) begin
            st_nxt.latched = line;
          end
          st_nxt.levels[lidx] = level;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/board_bus_decoder_irq_latch_core.sv
// Top level of the board bus decoder and interrupt latch: handshakes, state registers.
// Depends on bbd_pkg and bbd_decode.
//
// Usage: each input transaction is a CPU read, a CPU write or an interrupt line
// level change (in_command, in_address, in_write_data, in_line, in_line_level).
// Every input transaction yields exactly one result transaction carrying the
// decoded target, the offset within it, the read value and the gate-array status
// (irq request, mode register, LCD enable) as it stands after that transaction.
// Both channels use valid/stall; a transaction moves on an edge with valid high
// and stall low. The input is captured in a register, decoded by one level of
// logic and the state plus result are written when the transaction advances into
// the result register; throughput one transaction per cycle while out_stall is low.
// The rate is set by the single decode stage between input and result registers.
// When the receiver stalls, the result register holds, one more transaction
// waits in the input register, and in_stall then rises.
// The user must write the strap registers via cfg_ only while the block is idle;
// the block does not enforce this. Writing the open-enables strap reloads the
// interrupt mask, writing the display strap reloads the LCD enable. Synchronous
// reset clears both stages, loads the default straps and the state derived from them.
module board_bus_decoder_irq_latch_core import bbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [2:0]  in_line,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_target,
  output logic [18:0] out_target_offset,
  output logic [7:0]  out_read_data,
  output logic        out_irq_request,
  output logic [7:0]  out_mode_value,
  output logic        out_lcd_enabled,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_data
);

  logic        in_valid_r, in_valid_nxt;
  logic [1:0]  cmd_r;
  logic [23:0] addr_r;
  logic [7:0]  wdata_r;
  logic [2:0]  line_r;
  logic        level_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;
  logic        irq_r;
  logic [7:0]  mode_out_r;
  logic        lcd_out_r;
  cfg_t        cfg_r, cfg_nxt;
  state_t      st_r, st_nxt, st_dec;
  logic        accept;
  logic        advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  bbd_decode u_decode (
    .cmd    (cmd_r),
    .addr   (addr_r),
    .wdata  (wdata_r),
    .line   (line_r),
    .level  (level_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_dec)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Strap writes reload the state they seed
  always_comb begin
    cfg_nxt = cfg_r;
    st_nxt  = st_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_GEN:    cfg_nxt.first_gen = cfg_data[0];
        CFG_SUB_MCU:      cfg_nxt.sub_mcu = cfg_data[0];
        CFG_ENABLES_OPEN: begin
          cfg_nxt.enables_open = cfg_data[0];
          st_nxt.irq_mask      = {8{cfg_data[0]}};
        end
        CFG_HAS_PANEL:    cfg_nxt.has_panel = cfg_data[0];
        CFG_HAS_DISPLAY:  begin
          cfg_nxt.has_display = cfg_data[0];
          st_nxt.lcd_en       = cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      st_nxt = st_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{first_gen: 1'b0, sub_mcu: 1'b1, enables_open: 1'b0,
                       has_panel: 1'b1, has_display: 1'b1};
      st_r        <= '{mode: 8'h00, lcd_en: 1'b1, irq_mask: 8'h00, latched: 3'd0,
                       levels: '0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      line_r  <= in_line;
      level_r <= in_line_level;
    end
    if (advance) begin
      res_r      <= res_nxt;
      irq_r      <= (st_dec.latched != 3'd0);
      mode_out_r <= st_dec.mode;
      lcd_out_r  <= st_dec.lcd_en;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target        = res_r.target;
  assign out_target_offset = res_r.offset;
  assign out_read_data     = res_r.data;
  assign out_irq_request   = irq_r;
  assign out_mode_value    = mode_out_r;
  assign out_lcd_enabled   = lcd_out_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while result register could move");

  a_hold_waiting_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |=> in_valid_r)
    else $error("waiting transaction dropped from input register");

  a_latch_from_line_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.latched != 3'd0) |-> $past(advance && cmd_r == CMD_LINE))
    else $error("latched line set without a line event");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> out_valid_r)
    else $error("result missing after decode");

endmodule
